@@ rtl/lifecycle_heartbeat_controller_unit_defines.svh @@
// Assertion macros for the lifecycle heartbeat controller
`ifndef LIFECYCLE_HEARTBEAT_CONTROLLER_UNIT_DEFINES_SVH
`define LIFECYCLE_HEARTBEAT_CONTROLLER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define LHC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define LHC_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define LHC_ASSERT(lbl, clk, rstn, prop)
`define LHC_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

@@ rtl/lhc_pkg.sv @@
// Shared types and constants for the lifecycle heartbeat controller
package lhc_pkg;
  localparam logic [2:0] MODE_START    = 3'd0;
  localparam logic [2:0] MODE_RUNNING  = 3'd1;
  localparam logic [2:0] MODE_TICK     = 3'd2;
  localparam logic [2:0] MODE_STOPREQ  = 3'd3;
  localparam logic [2:0] MODE_STOPPED  = 3'd4;
  localparam logic [2:0] MODE_FAILED   = 3'd5;
  localparam logic [2:0] MODE_SNAPSHOT = 3'd6;

  localparam logic [2:0] PH_CREATED  = 3'd0;
  localparam logic [2:0] PH_STARTING = 3'd1;
  localparam logic [2:0] PH_RUNNING  = 3'd2;
  localparam logic [2:0] PH_STOPPING = 3'd3;
  localparam logic [2:0] PH_STOPPED  = 3'd4;
  localparam logic [2:0] PH_FAILED   = 3'd5;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_STATE = 3'd1;
  localparam logic [2:0] ST_BACK  = 3'd2;
  localparam logic [2:0] ST_CAUSE = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  localparam logic [2:0] CAUSE_NONE    = 3'd0;
  localparam logic [2:0] CAUSE_FAILURE = 3'd4;

  localparam logic [1:0] OUT_REJECT = 2'd0;
  localparam logic [1:0] OUT_NOBEAT = 2'd1;
  localparam logic [1:0] OUT_BEAT   = 2'd2;

  localparam logic [31:0] INTERVAL_RESET = 32'd1000;

  typedef struct packed {
    logic load;      // capture event and run decision
    logic div_start; // start the late / interval division
    logic div_step;  // one quotient bit
    logic commit;    // apply tick beat update
    logic emit;      // build result register
  } lhc_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } lhc_sts_t;
endpackage

@@ rtl/lhc_datapath.sv @@
// Lifecycle state, time checks, serial divider and result formation
module lhc_datapath import lhc_pkg::*; #(
  parameter int TimeBits = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lhc_cmd_t            cmd_i,
  output lhc_sts_t            sts_o,
  input  logic [31:0]         interval_i,
  input  logic [2:0]          mode_i,
  input  logic [TimeBits-1:0] now_i,
  input  logic [2:0]          cause_i,
  input  logic                text_i,
  output logic [3*TimeBits+15:0] res_lo_o,
  output logic [2*TimeBits-1:0]  res_hi_o,
  output logic                   dl_valid_o
);
  localparam int CntBits = $clog2(TimeBits + 1);
  localparam logic [TimeBits-1:0] TimeMax = '1;

  logic [2:0] phase_q, phase_d, cause_q, cause_d;
  logic [TimeBits-1:0] seen_q, seen_d, start_q, start_d, end_q, end_d;
  logic seen_v_q, seen_v_d, start_v_q, start_v_d, end_v_q, end_v_d;
  logic [TimeBits-1:0] dl_q, dl_d, beats_q, beats_d, missed_q, missed_d, bup_q, bup_d;
  logic [TimeBits-1:0] now_q;
  logic [2:0] status_q, status_d;
  logic [1:0] outc_q, outc_d;
  logic [TimeBits-1:0] iv;
  logic [TimeBits-1:0] rem_q, quo_q, dvd_q;
  logic [CntBits-1:0] cnt_q;
  logic [TimeBits:0] rem_sh, rem_sub;
  logic backwards, need_div_q, need_div_d;
  logic [TimeBits-1:0] eff, ut_now, uptime, base, sat;
  logic [TimeBits:0] sum;
  logic [TimeBits:0] sum2;

  assign iv = (interval_i == 32'd0) ? TimeBits'(1) : TimeBits'(interval_i);
  assign backwards = seen_v_q && (now_i < seen_q);

  function automatic logic [TimeBits-1:0] up_at(logic sv, logic [TimeBits-1:0] st,
      logic ev, logic [TimeBits-1:0] et, logic [TimeBits-1:0] t);
    logic [TimeBits-1:0] e;
    e = ev ? et : t;
    up_at = (!sv || e <= st) ? '0 : e - st;
  endfunction

  always_comb begin
    phase_d = phase_q; cause_d = cause_q; seen_d = seen_q; seen_v_d = seen_v_q;
    start_d = start_q; start_v_d = start_v_q; end_d = end_q; end_v_d = end_v_q;
    dl_d = dl_q; status_d = ST_OK; outc_d = OUT_REJECT; need_div_d = 1'b0;
    sum = {1'b0, now_i} + {1'b0, iv};
    unique case (mode_i)
      MODE_START: begin
        if (phase_q != PH_CREATED) status_d = ST_STATE;
        else if (backwards) status_d = ST_BACK;
        else begin
          seen_d = now_i; seen_v_d = 1'b1; start_d = now_i; start_v_d = 1'b1;
          phase_d = PH_STARTING;
        end
      end
      MODE_RUNNING: begin
        if (phase_q != PH_STARTING) status_d = ST_STATE;
        else if (backwards) status_d = ST_BACK;
        else begin
          seen_d = now_i; seen_v_d = 1'b1;
          dl_d = sum[TimeBits] ? TimeMax : sum[TimeBits-1:0];
          phase_d = PH_RUNNING;
        end
      end
      MODE_TICK: begin
        if (phase_q != PH_RUNNING) status_d = ST_STATE;
        else if (backwards) status_d = ST_BACK;
        else begin
          seen_d = now_i; seen_v_d = 1'b1;
          if (now_i < dl_q) outc_d = OUT_NOBEAT;
          else begin
            outc_d = OUT_BEAT; need_div_d = 1'b1;
          end
        end
      end
      MODE_STOPREQ: begin
        if (cause_i == CAUSE_NONE || cause_i >= CAUSE_FAILURE) status_d = ST_CAUSE;
        else if (phase_q == PH_STOPPED) status_d = ST_OK;
        else if (phase_q == PH_STOPPING) begin
          if (backwards) status_d = ST_BACK;
          else begin
            seen_d = now_i; seen_v_d = 1'b1;
          end
        end else if (phase_q != PH_STARTING && phase_q != PH_RUNNING) status_d = ST_STATE;
        else if (backwards) status_d = ST_BACK;
        else begin
          seen_d = now_i; seen_v_d = 1'b1; cause_d = cause_i; phase_d = PH_STOPPING;
        end
      end
      MODE_STOPPED: begin
        if (phase_q == PH_STOPPED) status_d = ST_OK;
        else if (phase_q != PH_STOPPING) status_d = ST_STATE;
        else if (backwards) status_d = ST_BACK;
        else begin
          seen_d = now_i; seen_v_d = 1'b1; end_d = now_i; end_v_d = 1'b1;
          phase_d = PH_STOPPED;
        end
      end
      MODE_FAILED: begin
        if (!text_i) status_d = ST_EMPTY;
        else if (phase_q == PH_FAILED) status_d = ST_OK;
        else if (phase_q == PH_STOPPED) status_d = ST_STATE;
        else if (backwards) status_d = ST_BACK;
        else begin
          seen_d = now_i; seen_v_d = 1'b1;
          if (!start_v_q) begin
            start_d = now_i; start_v_d = 1'b1;
          end
          cause_d = CAUSE_FAILURE; end_d = now_i; end_v_d = 1'b1; phase_d = PH_FAILED;
        end
      end
      MODE_SNAPSHOT: begin
        if (!backwards) begin
          seen_d = now_i; seen_v_d = 1'b1;
        end
      end
      default: status_d = ST_STATE;
    endcase
  end

  assign rem_sh = {rem_q, dvd_q[TimeBits-1]};
  assign rem_sub = rem_sh - {1'b0, iv};
  assign base = now_q - rem_q;
  assign sum2 = {1'b0, base} + {1'b0, iv};
  assign sat = sum2[TimeBits] ? TimeMax : sum2[TimeBits-1:0];
  assign ut_now = (seen_v_q && now_q < seen_q) ? seen_q : now_q;
  assign uptime = up_at(start_v_q, start_q, end_v_q, end_q, ut_now);
  assign eff = up_at(start_v_q, start_q, end_v_q, end_q, now_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CREATED; cause_q <= CAUSE_NONE;
      seen_q <= '0; seen_v_q <= 1'b0; start_q <= '0; start_v_q <= 1'b0;
      end_q <= '0; end_v_q <= 1'b0; dl_q <= '0; beats_q <= '0; missed_q <= '0;
      bup_q <= '0; need_div_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (cmd_i.load) begin
        phase_q <= phase_d; cause_q <= cause_d; seen_q <= seen_d; seen_v_q <= seen_v_d;
        start_q <= start_d; start_v_q <= start_v_d; end_q <= end_d; end_v_q <= end_v_d;
        dl_q <= dl_d; need_div_q <= need_div_d;
      end
      if (cmd_i.div_start) cnt_q <= CntBits'(TimeBits);
      else if (cmd_i.div_step) cnt_q <= cnt_q - 1'b1;
      if (cmd_i.commit) begin
        beats_q <= beats_q + 1'b1;
        missed_q <= missed_q + quo_q;
        bup_q <= eff;
        dl_q <= sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q <= now_i; status_q <= status_d; outc_q <= outc_d;
    end
    if (cmd_i.div_start) begin
      dvd_q <= now_q - dl_q; rem_q <= '0; quo_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= dvd_q << 1;
      if (!rem_sub[TimeBits]) begin
        rem_q <= rem_sub[TimeBits-1:0]; quo_q <= {quo_q[TimeBits-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[TimeBits-1:0]; quo_q <= {quo_q[TimeBits-2:0], 1'b0};
      end
    end
    if (cmd_i.emit) begin
      res_lo_o <= {uptime, missed_q, beats_q, 4'd0, cause_q, phase_q, outc_q,
                   status_q, status_q == ST_OK};
      res_hi_o <= {(phase_q == PH_RUNNING) ? dl_q : {TimeBits{1'b0}}, bup_q};
      dl_valid_o <= (phase_q == PH_RUNNING);
    end
  end

  assign sts_o.need_div = need_div_q;
  assign sts_o.div_done = (cnt_q == '0);
endmodule

@@ rtl/lhc_ctrl.sv @@
// Sequencer for event load, division and result handshake
module lhc_ctrl import lhc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  lhc_sts_t sts_i,
  output lhc_cmd_t cmd_o
);
`include "lifecycle_heartbeat_controller_unit_defines.svh"
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_DIV = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.load = 1'b1; state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1; state_d = S_DIV;
        end else begin
          cmd_o.emit = 1'b1; state_d = S_OUT;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) state_d = S_COMMIT;
        else cmd_o.div_step = 1'b1;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1; state_d = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1; state_d = S_OUT;
      end
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  `LHC_ASSERT(a_no_overlap, clk_i, rst_ni, !(in_ready_o && out_valid_o))
  `LHC_ASSERT(a_load_decide, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> state_q == S_DECIDE)
  `LHC_ASSERT(a_commit_emit, clk_i, rst_ni, cmd_o.commit |=> cmd_o.emit)
  `LHC_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> out_valid_o)
endmodule

@@ rtl/lifecycle_heartbeat_controller_unit.sv @@
// Top level of the lifecycle heartbeat controller
// One event in, one status transaction out. Each event is loaded and decided; a tick
// that emits a heartbeat then runs the bit-serial division of the late time by the
// interval, commits the beat update and builds the result. The next event is taken
// once the result is taken. Write the interval only while no event is in flight; an
// interval of 0 acts as 1.
module lifecycle_heartbeat_controller_unit import lhc_pkg::*; #(
  parameter int TIME_BITS = 48
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [TIME_BITS+7:0] s_axis_tdata, // mode, now_ms, stop_cause, pad
  input  logic s_axis_tuser,                  // failure_text_present
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // accepted, status, tick_outcome, lifecycle_now, recorded_cause, pad, beat_count,
  // missed_total, uptime_ms, last_beat_uptime_ms, deadline_ms
  output logic [5*TIME_BITS+15:0] m_axis_tdata,
  output logic m_axis_tuser                   // deadline_valid
);
  logic [31:0] iv_q;
  lhc_cmd_t cmd;
  lhc_sts_t sts;
  logic [3*TIME_BITS+15:0] lo;
  logic [2*TIME_BITS-1:0] hi;
  logic hi_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) iv_q <= INTERVAL_RESET;
    else if (cfg_we_i) iv_q <= cfg_wdata_i;
  end

  lhc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .sts_i(sts), .cmd_o(cmd)
  );

  lhc_datapath #(.TimeBits(TIME_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .interval_i(iv_q),
    .mode_i(s_axis_tdata[2:0]), .now_i(s_axis_tdata[TIME_BITS+2:3]),
    .cause_i(s_axis_tdata[TIME_BITS+5:TIME_BITS+3]), .text_i(s_axis_tuser),
    .res_lo_o(lo), .res_hi_o(hi), .dl_valid_o(hi_v)
  );

  assign m_axis_tdata = {hi, lo};
  assign m_axis_tuser = hi_v;
endmodule

@@ test/lhc_checker.sv @@
// Checker for the lifecycle heartbeat controller: predicts each status transaction and compares
`timescale 1ns / 1ps
module lhc_checker import lhc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [55:0]  s_tdata_i,
  input  logic         s_tuser_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [255:0] m_tdata_i,
  input  logic         m_tuser_i,
  output int           fail_count_o,
  output int           pending_o
);
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    logic        accepted;
    logic [2:0]  status;
    logic [1:0]  outcome;
    logic [2:0]  phase;
    logic [2:0]  cause;
    logic [47:0] beats;
    logic [47:0] missed;
    logic [47:0] uptime;
    logic [47:0] beat_uptime;
    logic [47:0] deadline;
    logic        deadline_valid;
  } status_t;

  status_t     status_q[$];
  logic [31:0] interval;
  logic [2:0]  phase;
  logic [2:0]  cause_reg;
  logic [47:0] last_time, start_time, end_time, deadline, beats, missed, beat_up;
  logic        last_valid, start_valid, end_valid;

  function automatic logic [63:0] period_ms();
    return (interval == 0) ? 64'd1 : {32'd0, interval};
  endfunction

  function automatic logic [47:0] sat_add(logic [63:0] a, logic [63:0] b);
    if (b > {16'd0, TIME_MAX} - a) return TIME_MAX;
    return 48'(a + b);
  endfunction

  function automatic logic [47:0] uptime_at(logic [47:0] now);
    logic [47:0] eff;
    if (!start_valid) return '0;
    eff = end_valid ? end_time : now;
    if (eff <= start_time) return '0;
    return eff - start_time;
  endfunction

  function automatic bit claim_time(logic [47:0] now);
    if (last_valid && now < last_time) return 0;
    last_time  = now;
    last_valid = 1;
    return 1;
  endfunction

  task automatic predict_event(input logic [2:0] mode, input logic [47:0] now,
                               input logic [2:0] cause, input logic text);
    status_t     r;
    logic [63:0] iv, late, q;
    logic [47:0] ut_now;
    r.status  = ST_OK;
    r.outcome = OUT_REJECT;
    case (mode)
      MODE_START: begin
        if (phase != PH_CREATED) r.status = ST_STATE;
        else if (!claim_time(now)) r.status = ST_BACK;
        else begin
          start_time = now; start_valid = 1; phase = PH_STARTING;
        end
      end
      MODE_RUNNING: begin
        if (phase != PH_STARTING) r.status = ST_STATE;
        else if (!claim_time(now)) r.status = ST_BACK;
        else begin
          deadline = sat_add({16'd0, now}, period_ms()); phase = PH_RUNNING;
        end
      end
      MODE_TICK: begin
        if (phase != PH_RUNNING) r.status = ST_STATE;
        else if (!claim_time(now)) r.status = ST_BACK;
        else if (now < deadline) r.outcome = OUT_NOBEAT;
        else begin
          iv = period_ms();
          late = {16'd0, now - deadline};
          q = late / iv;
          r.outcome = OUT_BEAT;
          beats = beats + 48'd1;
          missed = missed + 48'(q);
          beat_up = uptime_at(now);
          deadline = sat_add({16'd0, now} - (late % iv), iv);
        end
      end
      MODE_STOPREQ: begin
        if (cause == CAUSE_NONE || cause >= CAUSE_FAILURE) r.status = ST_CAUSE;
        else if (phase == PH_STOPPED) ;
        else if (phase == PH_STOPPING) begin
          if (!claim_time(now)) r.status = ST_BACK;
        end else if (phase != PH_STARTING && phase != PH_RUNNING) r.status = ST_STATE;
        else if (!claim_time(now)) r.status = ST_BACK;
        else begin
          cause_reg = cause; phase = PH_STOPPING;
        end
      end
      MODE_STOPPED: begin
        if (phase == PH_STOPPED) ;
        else if (phase != PH_STOPPING) r.status = ST_STATE;
        else if (!claim_time(now)) r.status = ST_BACK;
        else begin
          end_time = now; end_valid = 1; phase = PH_STOPPED;
        end
      end
      MODE_FAILED: begin
        if (!text) r.status = ST_EMPTY;
        else if (phase == PH_FAILED) ;
        else if (phase == PH_STOPPED) r.status = ST_STATE;
        else if (!claim_time(now)) r.status = ST_BACK;
        else begin
          if (!start_valid) begin
            start_time = now; start_valid = 1;
          end
          cause_reg = CAUSE_FAILURE; end_time = now; end_valid = 1; phase = PH_FAILED;
        end
      end
      MODE_SNAPSHOT: void'(claim_time(now));
      default: r.status = ST_STATE;
    endcase
    ut_now = (last_valid && now < last_time) ? last_time : now;
    r.accepted       = (r.status == ST_OK);
    r.phase          = phase;
    r.cause          = cause_reg;
    r.beats          = beats;
    r.missed         = missed;
    r.uptime         = uptime_at(ut_now);
    r.beat_uptime    = beat_up;
    r.deadline       = (phase == PH_RUNNING) ? deadline : '0;
    r.deadline_valid = (phase == PH_RUNNING);
    status_q.push_back(r);
  endtask

  task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    fail_count_o++;
  endtask

  task automatic compare_status();
    status_t w;
    if (status_q.size() == 0) begin
      $display("%0t status transaction with nothing expected", $time);
      fail_count_o++;
      return;
    end
    w = status_q.pop_front();
    if (m_tdata_i[0] !== w.accepted) report("accepted", m_tdata_i[0], w.accepted);
    if (m_tdata_i[3:1] !== w.status) report("status", m_tdata_i[3:1], w.status);
    if (m_tdata_i[5:4] !== w.outcome) report("tick_outcome", m_tdata_i[5:4], w.outcome);
    if (m_tdata_i[8:6] !== w.phase) report("lifecycle_now", m_tdata_i[8:6], w.phase);
    if (m_tdata_i[11:9] !== w.cause) report("recorded_cause", m_tdata_i[11:9], w.cause);
    if (m_tdata_i[63:16] !== w.beats) report("beat_count", m_tdata_i[63:16], w.beats);
    if (m_tdata_i[111:64] !== w.missed) report("missed_total", m_tdata_i[111:64], w.missed);
    if (m_tdata_i[159:112] !== w.uptime) report("uptime_ms", m_tdata_i[159:112], w.uptime);
    if (m_tdata_i[207:160] !== w.beat_uptime)
      report("last_beat_uptime_ms", m_tdata_i[207:160], w.beat_uptime);
    if (m_tdata_i[255:208] !== w.deadline) report("deadline_ms", m_tdata_i[255:208], w.deadline);
    if (m_tuser_i !== w.deadline_valid) report("deadline_valid", m_tuser_i, w.deadline_valid);
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    interval = INTERVAL_RESET;
    phase = PH_CREATED;
    cause_reg = CAUSE_NONE;
    {last_time, start_time, end_time, deadline, beats, missed, beat_up} = '0;
    {last_valid, start_valid, end_valid} = '0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) interval = cfg_wdata_i;
      if (s_tvalid_i && s_tready_i)
        predict_event(s_tdata_i[2:0], s_tdata_i[50:3], s_tdata_i[53:51], s_tuser_i);
      if (m_tvalid_i && m_tready_i) compare_status();
      pending_o = status_q.size();
    end
  end
endmodule

@@ test/testbench.sv @@
// Testbench top for the lifecycle heartbeat controller: stimulus, idling and verdict
`timescale 1ns / 1ps
module testbench;
  import lhc_pkg::*;

  localparam logic [2:0]  MODE_UNKNOWN    = 3'd7;
  localparam logic [2:0]  CAUSE_REQUESTED = 3'd1;
  localparam logic [2:0]  CAUSE_RUNFOR    = 3'd2;
  localparam logic [2:0]  CAUSE_SIGNAL    = 3'd3;
  localparam logic [47:0] TIME_MAX        = 48'hFFFF_FFFF_FFFF;
  localparam int          DRAIN_CYCLES    = 80;
  localparam int          CYCLE_LIMIT     = 2000000;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         cfg_we = 0;
  logic [31:0]  cfg_wdata = '0;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [55:0]  s_tdata = '0;
  logic         s_tuser = 0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [255:0] m_tdata;
  logic         m_tuser;
  int           fail_count, pending, cycles;
  int           send_idle_pct, stall_pct;
  int           beat_events;
  logic [31:0]  interval_now;
  logic [47:0]  clock_ms;

  always #6 clk_i = ~clk_i;

  lifecycle_heartbeat_controller_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
    .s_axis_tuser(s_tuser), .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
    .m_axis_tdata(m_tdata), .m_axis_tuser(m_tuser)
  );

  lhc_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready), .s_tdata_i(s_tdata), .s_tuser_i(s_tuser),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready), .m_tdata_i(m_tdata), .m_tuser_i(m_tuser),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
    if (m_tvalid && m_tready && m_tdata[5:4] == OUT_BEAT) beat_events++;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("** lifecycle_heartbeat_controller_unit: FAILED **");
      $finish;
    end
  end

  task automatic send_event(input logic [2:0] mode, input logic [47:0] now,
                            input logic [2:0] cause, input logic text);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk_i);
    end
    s_tvalid <= 1;
    s_tdata  <= {2'b00, cause, now, mode};
    s_tuser  <= text;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_interval(input logic [31:0] value);
    s_tvalid <= 0;
    drain();
    cfg_we <= 1;
    cfg_wdata <= value;
    interval_now = value;
    @(posedge clk_i);
    cfg_we <= 0;
  endtask

  task automatic random_event();
    int          r;
    logic [63:0] iv, step;
    logic [2:0]  mode, cause;
    logic        text;
    r = $urandom_range(99);
    iv = (interval_now == 0) ? 64'd1 : {32'd0, interval_now};
    if (r < 70) begin
      step = (iv * $urandom_range(0, 2500)) / 1000 + $urandom_range(0, 2);
      clock_ms = clock_ms + 48'(step);
      send_event(MODE_TICK, clock_ms, 3'($urandom), 1'($urandom));
    end else if (r < 76) begin
      send_event(MODE_TICK, clock_ms - 48'($urandom_range(1, 50)), CAUSE_NONE, 0);
    end else if (r < 82) begin
      if ($urandom_range(1)) clock_ms = clock_ms + 48'($urandom_range(0, 30));
      send_event(MODE_SNAPSHOT, clock_ms - 48'($urandom_range(0, 1) * 20),
                 3'($urandom), 1'($urandom));
    end else if (r < 94) begin
      mode = 3'($urandom);
      cause = 3'($urandom);
      text = 1'($urandom);
      // keep the run alive: no stop with a valid cause, no failure with a message
      if (mode == MODE_STOPREQ && cause != CAUSE_NONE && cause < CAUSE_FAILURE)
        cause = CAUSE_NONE + 3'($urandom_range(0, 1)) * 3'd5;
      if (mode == MODE_FAILED) text = 0;
      send_event(mode, clock_ms, cause, text);
    end else begin
      send_event(MODE_TICK, clock_ms, CAUSE_NONE, 0);
    end
  endtask

  initial begin
    logic [31:0] phase_interval[6];
    int          pct_pairs[4][2];
    cycles = 0;
    beat_events = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    interval_now = INTERVAL_RESET;
    clock_ms = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send_event(MODE_TICK, 48'd1, CAUSE_NONE, 0);
    send_event(MODE_STOPREQ, 48'd1, CAUSE_REQUESTED, 0);
    send_event(MODE_STOPPED, 48'd1, CAUSE_NONE, 0);
    send_event(MODE_UNKNOWN, 48'd1, CAUSE_NONE, 1);
    send_event(MODE_FAILED, 48'd1, CAUSE_NONE, 0);
    send_event(MODE_RUNNING, 48'd1, CAUSE_NONE, 0);
    send_event(MODE_SNAPSHOT, 48'd5, CAUSE_NONE, 0);
    send_event(MODE_SNAPSHOT, 48'd2, CAUSE_NONE, 0);
    send_event(MODE_START, 48'd3, CAUSE_NONE, 0);
    send_event(MODE_START, 48'd10, CAUSE_NONE, 0);
    send_event(MODE_START, 48'd11, CAUSE_NONE, 0);
    send_event(MODE_RUNNING, 48'd9, CAUSE_NONE, 0);
    send_event(MODE_RUNNING, 48'd20, CAUSE_NONE, 0);
    send_event(MODE_TICK, 48'd20, CAUSE_NONE, 0);
    send_event(MODE_TICK, 48'd1020, CAUSE_NONE, 0);
    send_event(MODE_TICK, 48'd5500, CAUSE_NONE, 0);
    send_event(MODE_STOPREQ, 48'd5500, CAUSE_NONE, 0);
    send_event(MODE_STOPREQ, 48'd5500, CAUSE_FAILURE, 0);
    send_event(MODE_STOPREQ, 48'd5500, 3'd5, 0);
    send_event(MODE_STOPREQ, 48'd5500, 3'd7, 0);
    clock_ms = 48'd5500;

    phase_interval = '{32'd1000, 32'd1, 32'd0, 32'hFFFF_FFFF,
                       32'($urandom_range(2, 40)), $urandom};
    pct_pairs = '{'{0, 0}, '{74, 0}, '{0, 74}, '{22, 22}};
    foreach (phase_interval[p]) begin
      write_interval(phase_interval[p]);
      send_idle_pct = pct_pairs[p % 4][0];
      stall_pct = pct_pairs[p % 4][1];
      repeat (160) random_event();
    end

    // jump near the top of the time range: large missed count, then saturated deadlines
    send_idle_pct = 22;
    stall_pct = 22;
    write_interval(32'hFFFF_FFFF);
    clock_ms = TIME_MAX - 48'h1_0000_0000 - 48'($urandom_range(0, 1000));
    send_event(MODE_TICK, clock_ms, CAUSE_NONE, 0);
    send_event(MODE_TICK, TIME_MAX - 48'd5, CAUSE_NONE, 0);
    write_interval(32'd1);
    send_event(MODE_TICK, TIME_MAX - 48'd1, CAUSE_NONE, 0);
    send_event(MODE_TICK, TIME_MAX, CAUSE_NONE, 0);
    send_event(MODE_TICK, TIME_MAX, CAUSE_NONE, 0);
    clock_ms = TIME_MAX;

    if ($urandom_range(1)) begin
      send_event(MODE_STOPREQ, clock_ms, 3'($urandom_range(CAUSE_REQUESTED, CAUSE_SIGNAL)), 0);
      send_event(MODE_STOPREQ, clock_ms - 48'd3, CAUSE_RUNFOR, 0);
      send_event(MODE_STOPREQ, clock_ms, CAUSE_SIGNAL, 0);
      send_event(MODE_FAILED, clock_ms, CAUSE_NONE, 0);
      send_event(MODE_STOPPED, clock_ms - 48'd2, CAUSE_NONE, 0);
      send_event(MODE_STOPPED, clock_ms, CAUSE_NONE, 0);
      send_event(MODE_STOPPED, 48'd0, CAUSE_NONE, 0);
      send_event(MODE_STOPREQ, 48'd0, CAUSE_REQUESTED, 0);
      send_event(MODE_FAILED, clock_ms, CAUSE_NONE, 1);
    end else begin
      send_event(MODE_FAILED, clock_ms - 48'd1, CAUSE_NONE, 1);
      send_event(MODE_FAILED, clock_ms, CAUSE_NONE, 1);
      send_event(MODE_FAILED, 48'd0, CAUSE_NONE, 1);
      send_event(MODE_STOPREQ, clock_ms, CAUSE_SIGNAL, 0);
      send_event(MODE_STOPPED, clock_ms, CAUSE_NONE, 0);
      send_event(MODE_START, clock_ms, CAUSE_NONE, 0);
    end
    send_event(MODE_SNAPSHOT, 48'd7, CAUSE_NONE, 0);
    send_event(MODE_TICK, clock_ms, CAUSE_NONE, 0);
    s_tvalid <= 0;
    drain();

    $display("covered: full lifecycle, rejections of every kind, six intervals incl. 0 and max,");
    $display("  %0d heartbeats seen, time up to the saturation point", beat_events);
    if (fail_count == 0) begin
      $display("** lifecycle_heartbeat_controller_unit: PASSED **");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("** lifecycle_heartbeat_controller_unit: FAILED **");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl
rtl/lhc_pkg.sv
rtl/lhc_datapath.sv
rtl/lhc_ctrl.sv
rtl/lifecycle_heartbeat_controller_unit.sv
test/lhc_checker.sv
test/testbench.sv
